>>> hdl/pmu_pkg.sv
package pmu_pkg;

    localparam int MaxTerms = 32;
    localparam int CoeffW   = 32;

    // operand kind codes
    localparam logic KIND_FIRST  = 1'b0;
    localparam logic KIND_SECOND = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_EMIT,
        ST_FLUSH
    } state_t;

    // strobes from the sequencer to every cell of the chain
    typedef struct packed {
        logic load;       // store coeff in the cell addressed by count
        logic load_zero;  // store zero instead (empty first polynomial)
        logic mul;        // register term * b
        logic acc;        // sum += product
        logic shift;      // sum <= right neighbor's sum
    } cell_ctl_t;

endpackage

>>> hdl/pmu_in_if.sv
interface pmu_in_if;
    logic                              valid;
    logic                              ready;
    logic                              kind;
    logic signed [pmu_pkg::CoeffW-1:0] coeff;
    logic                              last;

    modport source (output valid, output kind, output coeff, output last, input ready);
    modport sink   (input valid, input kind, input coeff, input last, output ready);
endinterface

>>> hdl/pmu_out_if.sv
interface pmu_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [pmu_pkg::CoeffW-1:0] product_coeff;
    logic                              final_res;

    modport source (output valid, output product_coeff, output final_res, input ready);
    modport sink   (input valid, input product_coeff, input final_res, output ready);
endinterface

>>> hdl/polynomial_multiply_unit.sv
// Channel   Dir   Fields                          Beat
// -------   ---   -----------------------------   ----------------------------------
// operand   in    kind, coeff[31:0] s, last       one coefficient, valid & ready
// result    out   product_coeff[31:0] s, final_res one product coefficient, valid & ready
//
// A first-polynomial beat is taken while idle. A second-polynomial beat steps
// through accept, multiply, accumulate and emit, with operand not ready until
// idle again; one marked last then flushes the remaining partial sums to drain
// the tail. The 32x32 multiplier in every cell is registered before the accumulate.
// Reset clears the partial sums, term count and sequencer; stored terms are not.
// A stalled result holds the sequencer in emit/flush; result register frees operand.
module polynomial_multiply_unit #(
    parameter int MAX_TERMS = pmu_pkg::MaxTerms
) (
    input  logic      clk,
    input  logic      rst_n,
    pmu_in_if.sink    operand,
    pmu_out_if.source result
);

    localparam int CNT_W = $clog2(MAX_TERMS + 1);

    pmu_pkg::cell_ctl_t         ctl;
    logic [CNT_W-1:0]           count;
    logic [pmu_pkg::CoeffW-1:0] b;
    logic [pmu_pkg::CoeffW-1:0] load_val;
    // sums[k] is partial sum k; sums[MAX_TERMS] feeds zero into the tail cell
    logic [pmu_pkg::CoeffW-1:0] sums [MAX_TERMS+1];

    assign load_val        = operand.coeff;
    assign sums[MAX_TERMS] = '0;

    // Sequencer: term count, result register and cell strobes.
    pmu_ctrl #(
        .MAX_TERMS (MAX_TERMS),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .operand  (operand),
        .result   (result),
        .head_sum (sums[0]),
        .ctl      (ctl),
        .count    (count),
        .b        (b)
    );

    // Chain of cells, transposed-FIR style: cell k keeps term k and partial sum k;
    // on each emit or flush the sums move one cell toward the head, which is the output.
    for (genvar k = 0; k < MAX_TERMS; k++)
    begin : g_cell
        pmu_cell #(
            .IDX   (k),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .count    (count),
            .load_val (load_val),
            .b        (b),
            .sum_in   (sums[k+1]),
            .sum_out  (sums[k])
        );
    end

endmodule

>>> hdl/pmu_cell.sv
module pmu_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 6
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  pmu_pkg::cell_ctl_t        ctl,
    input  logic [CNT_W-1:0]          count,
    input  logic [pmu_pkg::CoeffW-1:0] load_val,
    input  logic [pmu_pkg::CoeffW-1:0] b,
    input  logic [pmu_pkg::CoeffW-1:0] sum_in,
    output logic [pmu_pkg::CoeffW-1:0] sum_out
);

    logic [pmu_pkg::CoeffW-1:0] term_reg;
    logic [pmu_pkg::CoeffW-1:0] prod_reg;
    logic [pmu_pkg::CoeffW-1:0] sum_reg;
    logic [pmu_pkg::CoeffW-1:0] sum_next;
    logic                       hit;
    logic                       active;

    assign hit    = (count == CNT_W'(IDX));
    assign active = (count > CNT_W'(IDX));

    // coefficient store, written once per first-polynomial term
    always_ff @(posedge clk)
    begin
        if (ctl.load && hit)
        begin
            term_reg <= ctl.load_zero ? '0 : load_val;
        end
    end

    // low 32 bits of the product; idle cells contribute zero
    always_ff @(posedge clk)
    begin
        if (ctl.mul)
        begin
            prod_reg <= active ? term_reg * b : '0;
        end
    end

    always_comb
    begin
        sum_next = sum_reg;
        if (ctl.acc)
        begin
            sum_next = sum_reg + prod_reg;
        end
        else if (ctl.shift)
        begin
            sum_next = sum_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum_out = sum_reg;

endmodule

>>> hdl/pmu_ctrl.sv
module pmu_ctrl #(
    parameter int MAX_TERMS = pmu_pkg::MaxTerms,
    parameter int CNT_W     = $clog2(MAX_TERMS + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    pmu_in_if.sink                     operand,
    pmu_out_if.source                  result,
    input  logic [pmu_pkg::CoeffW-1:0] head_sum,
    output pmu_pkg::cell_ctl_t         ctl,
    output logic [CNT_W-1:0]           count,
    output logic [pmu_pkg::CoeffW-1:0] b
);

    pmu_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic             done_reg, done_next;
    logic [pmu_pkg::CoeffW-1:0] b_reg, b_next;
    logic             last_reg, last_next;
    logic             out_valid_reg, out_valid_next;
    logic [pmu_pkg::CoeffW-1:0] out_coeff_reg;
    logic             out_final_reg;
    logic             out_load;
    logic             out_final;
    logic             out_free;
    logic             accept;

    assign operand.ready = (state_reg == pmu_pkg::ST_IDLE);
    assign accept        = operand.valid && operand.ready;
    assign out_free      = !out_valid_reg || result.ready;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        rem_next   = rem_reg;
        done_next  = done_reg;
        b_next     = b_reg;
        last_next  = last_reg;
        ctl        = '0;
        out_load   = 1'b0;
        out_final  = 1'b0;
        unique case (state_reg)
            pmu_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (operand.kind == pmu_pkg::KIND_FIRST)
                    begin
                        if (!done_reg)
                        begin
                            if (count_reg < CNT_W'(MAX_TERMS))
                            begin
                                ctl.load   = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                            if (operand.last)
                            begin
                                done_next = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        done_next = 1'b1;
                        b_next    = operand.coeff;
                        last_next = operand.last;
                        if (count_reg == '0)
                        begin
                            ctl.load      = 1'b1;
                            ctl.load_zero = 1'b1;
                            count_next    = CNT_W'(1);
                        end
                        state_next = pmu_pkg::ST_MUL;
                    end
                end
            end
            pmu_pkg::ST_MUL:
            begin
                ctl.mul    = 1'b1;
                state_next = pmu_pkg::ST_ACC;
            end
            pmu_pkg::ST_ACC:
            begin
                ctl.acc    = 1'b1;
                state_next = pmu_pkg::ST_EMIT;
            end
            pmu_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    out_final = last_reg && (count_reg == CNT_W'(1));
                    ctl.shift = 1'b1;
                    if (last_reg && count_reg != CNT_W'(1))
                    begin
                        rem_next   = count_reg - CNT_W'(1);
                        state_next = pmu_pkg::ST_FLUSH;
                    end
                    else
                    begin
                        if (last_reg)
                        begin
                            count_next = '0;
                            done_next  = 1'b0;
                        end
                        state_next = pmu_pkg::ST_IDLE;
                    end
                end
            end
            pmu_pkg::ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    out_final = (rem_reg == CNT_W'(1));
                    ctl.shift = 1'b1;
                    rem_next  = rem_reg - CNT_W'(1);
                    if (rem_reg == CNT_W'(1))
                    begin
                        count_next = '0;
                        done_next  = 1'b0;
                        state_next = pmu_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = pmu_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pmu_pkg::ST_IDLE;
            count_reg     <= '0;
            rem_reg       <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rem_reg       <= rem_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg    <= b_next;
        last_reg <= last_next;
        if (out_load)
        begin
            out_coeff_reg <= head_sum;
            out_final_reg <= out_final;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.product_coeff = out_coeff_reg;
    assign result.final_res     = out_final_reg;
    assign count                = count_reg;
    assign b                    = b_reg;

endmodule

>>> hdl/pmu_checker.sv
module pmu_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       operand_valid,
    input logic                       operand_ready,
    input logic                       operand_kind,
    input logic                       result_valid,
    input logic                       result_ready,
    input logic [pmu_pkg::CoeffW-1:0] result_coeff,
    input logic                       result_final
);

    logic op_acc;
    assign op_acc = operand_valid && operand_ready;

    // result beat held while stalled
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result_coeff) && $stable(result_final))
        else $error("result payload changed while stalled");

    // a second-polynomial beat keeps the sequencer busy and drops operand ready
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        op_acc && operand_kind == pmu_pkg::KIND_SECOND |=> !operand_ready)
        else $error("operand taken during multiply");

    // first-polynomial beats never produce a result
    a_first_silent: assert property (@(posedge clk) disable iff (!rst_n)
        op_acc && operand_kind == pmu_pkg::KIND_FIRST && !result_valid |=> !result_valid)
        else $error("result after first-polynomial beat");

endmodule

bind polynomial_multiply_unit pmu_checker u_pmu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .operand_valid (operand.valid),
    .operand_ready (operand.ready),
    .operand_kind  (operand.kind),
    .result_valid  (result.valid),
    .result_ready  (result.ready),
    .result_coeff  (result.product_coeff),
    .result_final  (result.final_res)
);

>>> test/polynomial_multiply_unit_tb.sv
`timescale 1ns / 100ps

module polynomial_multiply_unit_tb;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = pmu_pkg::MaxTerms + 16;
    localparam int RANDOM_BEATS = 400;

    typedef struct packed {
        logic signed [31:0] coeff;
        logic               fin;
    } prod_term_t;

    logic clk;
    logic rst_n;

    pmu_in_if  operand_ch ();
    pmu_out_if result_ch ();

    polynomial_multiply_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .operand (operand_ch),
        .result  (result_ch)
    );

    // predictor state
    logic [31:0] first_terms  [pmu_pkg::MaxTerms];
    logic [31:0] partial_sums [pmu_pkg::MaxTerms];
    int          first_count;
    bit          first_done;

    prod_term_t  expected_terms [$];
    int          error_count;
    int          random_beats;
    int          cycle_count;
    bit          idle_on;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // convolution predictor, one accepted beat at a time
    function automatic void convolve_beat(input logic k, input logic [31:0] b, input logic l);
        int         n;
        prod_term_t t;
        if (k == pmu_pkg::KIND_FIRST)
        begin
            if (first_done)
                return;
            if (first_count < pmu_pkg::MaxTerms)
            begin
                first_terms[first_count] = b;
                first_count++;
            end
            if (l)
                first_done = 1'b1;
            return;
        end
        first_done = 1'b1;
        if (first_count == 0)
        begin
            first_terms[0] = '0;
            first_count    = 1;
        end
        n = first_count;
        for (int i = 0; i < n; i++)
            partial_sums[i] = partial_sums[i] + first_terms[i] * b;
        t.coeff = partial_sums[0];
        t.fin   = l && (n == 1);
        expected_terms = {expected_terms, t};
        for (int i = 0; i + 1 < n; i++)
            partial_sums[i] = partial_sums[i + 1];
        partial_sums[n - 1] = '0;
        if (l)
        begin
            for (int i = 0; i + 1 < n; i++)
            begin
                t.coeff = partial_sums[i];
                t.fin   = (i + 2 == n);
                expected_terms = {expected_terms, t};
            end
            for (int i = 0; i < pmu_pkg::MaxTerms; i++)
                partial_sums[i] = '0;
            first_count = 0;
            first_done  = 1'b0;
        end
    endfunction

    function automatic logic [31:0] rand_coeff();
        logic [31:0] corners [5];
        corners = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
        if ($urandom_range(99) < 15)
            return corners[$urandom_range(4)];
        return $urandom;
    endfunction

    // one operand beat; valid stays high across back-to-back beats
    task automatic send_beat(input logic k, input logic [31:0] c, input logic l);
        while (idle_on && $urandom_range(99) < 7)
        begin
            operand_ch.valid <= 1'b0;
            @(posedge clk);
        end
        operand_ch.valid <= 1'b1;
        operand_ch.kind  <= k;
        operand_ch.coeff <= c;
        operand_ch.last  <= l;
        @(posedge clk);
        while (!operand_ch.ready)
            @(posedge clk);
        convolve_beat(k, c, l);
    endtask

    task automatic pause_until_drained();
        operand_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_terms.size() != 0)
            @(posedge clk);
    endtask

    // result checker and receiver stalls
    always @(posedge clk)
    begin
        prod_term_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_terms.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result beat: coeff %0d final %0b", $time,
                         result_ch.product_coeff, result_ch.final_res);
            end
            else
            begin
                want = expected_terms.pop_front();
                if (result_ch.product_coeff !== want.coeff)
                begin
                    error_count++;
                    $display("%0t: product_coeff mismatch: expected %0d, actual %0d", $time,
                             want.coeff, result_ch.product_coeff);
                end
                if (result_ch.final_res !== want.fin)
                begin
                    error_count++;
                    $display("%0t: final_res mismatch: expected %0b, actual %0b", $time,
                             want.fin, result_ch.final_res);
                end
            end
        end
        result_ch.ready <= !(idle_on && $urandom_range(99) < 7);
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic test_basic();
        send_beat(pmu_pkg::KIND_FIRST,  32'd3,          1'b0);
        send_beat(pmu_pkg::KIND_FIRST,  -32'sd2,        1'b1);
        send_beat(pmu_pkg::KIND_SECOND, 32'd5,          1'b0);
        send_beat(pmu_pkg::KIND_SECOND, 32'd7,          1'b1);
    endtask

    // wrap at 32 bits with the largest magnitudes
    task automatic test_extremes();
        send_beat(pmu_pkg::KIND_FIRST,  32'h7FFF_FFFF, 1'b0);
        send_beat(pmu_pkg::KIND_FIRST,  32'h8000_0000, 1'b0);
        send_beat(pmu_pkg::KIND_FIRST,  32'hFFFF_FFFF, 1'b1);
        send_beat(pmu_pkg::KIND_SECOND, 32'h8000_0000, 1'b0);
        send_beat(pmu_pkg::KIND_SECOND, 32'h7FFF_FFFF, 1'b0);
        send_beat(pmu_pkg::KIND_SECOND, 32'hFFFF_FFFF, 1'b0);
        send_beat(pmu_pkg::KIND_SECOND, 32'h0,         1'b1);
    endtask

    // one stored term: the first result is already final
    task automatic test_single_term();
        send_beat(pmu_pkg::KIND_FIRST,  32'hDEAD_BEEF, 1'b1);
        send_beat(pmu_pkg::KIND_SECOND, 32'h1234_5678, 1'b1);
    endtask

    // no first polynomial at all: taken as a single zero
    task automatic test_empty_first();
        send_beat(pmu_pkg::KIND_SECOND, 32'd9,  1'b0);
        send_beat(pmu_pkg::KIND_SECOND, 32'd11, 1'b1);
    endtask

    // second poly starts before first was marked last; later first beats ignored
    task automatic test_implicit_end();
        send_beat(pmu_pkg::KIND_FIRST,  32'd4,  1'b0);
        send_beat(pmu_pkg::KIND_FIRST,  32'd6,  1'b0);
        send_beat(pmu_pkg::KIND_SECOND, 32'd2,  1'b0);
        send_beat(pmu_pkg::KIND_FIRST,  32'd99, 1'b1);
        send_beat(pmu_pkg::KIND_SECOND, 32'd3,  1'b1);
    endtask

    task automatic test_ignored_first();
        send_beat(pmu_pkg::KIND_FIRST,  32'd8,          1'b1);
        send_beat(pmu_pkg::KIND_FIRST,  32'hFFFF_0000,  1'b0);
        send_beat(pmu_pkg::KIND_FIRST,  32'd77,         1'b1);
        send_beat(pmu_pkg::KIND_SECOND, -32'sd1,        1'b1);
    endtask

    // more first terms than fit; last mark lands on a dropped one; no idling here
    task automatic test_overflow();
        idle_on = 1'b0;
        for (int i = 0; i < pmu_pkg::MaxTerms + 2; i++)
            send_beat(pmu_pkg::KIND_FIRST, rand_coeff(), i == pmu_pkg::MaxTerms + 1);
        send_beat(pmu_pkg::KIND_SECOND, rand_coeff(), 1'b0);
        send_beat(pmu_pkg::KIND_SECOND, rand_coeff(), 1'b0);
        send_beat(pmu_pkg::KIND_SECOND, rand_coeff(), 1'b1);
        idle_on = 1'b1;
    endtask

    // one product: mostly well formed, sometimes empty, implicit end or noise
    task automatic random_product();
        int  first_len;
        int  second_len;
        int  pick;
        bit  implicit;
        pick = $urandom_range(99);
        if (pick < 5)
            first_len = 0;
        else if (pick < 12)
            first_len = $urandom_range(pmu_pkg::MaxTerms + 4, pmu_pkg::MaxTerms - 2);
        else
            first_len = $urandom_range(8, 1);
        implicit   = ($urandom_range(99) < 10);
        second_len = ($urandom_range(99) < 10) ? $urandom_range(12, 9) : $urandom_range(8, 1);
        for (int i = 0; i < first_len; i++)
        begin
            send_beat(pmu_pkg::KIND_FIRST, rand_coeff(), !implicit && (i == first_len - 1));
            random_beats++;
        end
        if (!implicit && first_len > 0 && $urandom_range(99) < 10)
            send_beat(pmu_pkg::KIND_FIRST, rand_coeff(), 1'($urandom_range(1)));
        for (int i = 0; i < second_len; i++)
        begin
            if (i > 0 && $urandom_range(99) < 5)
                send_beat(pmu_pkg::KIND_FIRST, rand_coeff(), 1'($urandom_range(1)));
            send_beat(pmu_pkg::KIND_SECOND, rand_coeff(), i == second_len - 1);
            random_beats++;
        end
    endtask

    task automatic test_random();
        int next_pause;
        random_beats = 0;
        next_pause   = 60;
        while (random_beats < RANDOM_BEATS)
        begin
            idle_on = !(random_beats >= 150 && random_beats < 230);
            random_product();
            if (random_beats >= next_pause)
            begin
                pause_until_drained();
                next_pause += 90;
            end
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        error_count = 0;
        idle_on     = 1'b1;
        first_count = 0;
        first_done  = 1'b0;
        for (int i = 0; i < pmu_pkg::MaxTerms; i++)
        begin
            first_terms[i]  = '0;
            partial_sums[i] = '0;
        end
        rst_n            <= 1'b0;
        operand_ch.valid <= 1'b0;
        operand_ch.kind  <= pmu_pkg::KIND_FIRST;
        operand_ch.coeff <= '0;
        operand_ch.last  <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic();
        test_extremes();
        test_single_term();
        test_empty_first();
        test_implicit_end();
        test_ignored_first();
        test_overflow();
        test_random();

        operand_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_terms.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> polynomial_multiply_unit.f
hdl/pmu_pkg.sv
hdl/pmu_in_if.sv
hdl/pmu_out_if.sv
hdl/pmu_cell.sv
hdl/pmu_ctrl.sv
hdl/polynomial_multiply_unit.sv
hdl/pmu_checker.sv
test/polynomial_multiply_unit_tb.sv
